[hdl/signed_binary_to_ascii_radix_core_macros.svh]
// assertion macros for the signed binary to ascii radix core
`ifndef SIGNED_BINARY_TO_ASCII_RADIX_CORE_MACROS_SVH
`define SIGNED_BINARY_TO_ASCII_RADIX_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SBAR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SBAR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sbar_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and the digit encoder for the radix converter
package sbar_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int RADIX_W         = 6;
    localparam int CHAR_W          = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_SEVEN = 8'h37;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic push;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic step_last;
        logic quot_zero;
        logic neg;
        logic idx_last;
        logic out_free;
    } t_stat;

    // digit value to ascii, 0-9 then A-Z
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-RADIX_W){1'b0}}, d};
        if (d < DEC_DIGITS) begin
            return CHAR_ZERO + ext;
        end
        return CHAR_SEVEN + ext;
    endfunction

endpackage

[hdl/sbar_datapath.sv]
`timescale 1ns / 1ps
// datapath: magnitude, bit-serial divider, digit stack and output register
module sbar_datapath #(
    parameter int VALUE_WIDTH = sbar_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sbar_pkg::t_cmd                      i_cmd,
    output sbar_pkg::t_stat                     o_stat,
    input  logic signed [VALUE_WIDTH-1:0]       i_value,
    input  logic [sbar_pkg::RADIX_W-1:0]        i_radix,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [sbar_pkg::CHAR_W-1:0]         o_character,
    output logic                                o_last
);

    localparam int BW = $clog2(VALUE_WIDTH);
    localparam int CW = $clog2(VALUE_WIDTH + 1);
    localparam int IW = $clog2(VALUE_WIDTH);
    localparam int RW = sbar_pkg::RADIX_W;

    logic [VALUE_WIDTH-1:0] r_quot;
    logic [RW-1:0]          r_rem;
    logic [RW-1:0]          r_radix;
    logic                   r_neg;
    logic [BW-1:0]          r_bit;
    logic [CW-1:0]          r_count;
    logic [RW-1:0]          r_stack [VALUE_WIDTH];
    logic                   r_o_valid;
    logic [sbar_pkg::CHAR_W-1:0] r_character;
    logic                   r_last;

    logic [VALUE_WIDTH-1:0] n_quot;
    logic [RW-1:0]          n_rem;
    logic [RW:0]            rem_shift;
    logic [RW:0]            rem_sub;
    logic                   rem_ge;
    logic [VALUE_WIDTH-1:0] in_mag;
    logic                   in_neg;
    logic [RW-1:0]          in_radix;
    logic [CW-1:0]          rd_count;
    logic [RW-1:0]          rd_digit;

    // input magnitude and clamped radix
    always_comb begin
        in_neg = i_value[VALUE_WIDTH-1];
        in_mag = in_neg ? (~i_value + 1'b1) : i_value;
        if (i_radix < sbar_pkg::RADIX_MIN) begin
            in_radix = sbar_pkg::RADIX_MIN;
        end else if (i_radix > sbar_pkg::RADIX_MAX) begin
            in_radix = sbar_pkg::RADIX_MAX;
        end else begin
            in_radix = i_radix;
        end
    end

    // one restoring division step, quotient bit shifted in at the bottom
    always_comb begin
        rem_shift = {r_rem, r_quot[VALUE_WIDTH-1]};
        rem_ge    = rem_shift >= {1'b0, r_radix};
        rem_sub   = rem_shift - {1'b0, r_radix};
        n_rem     = rem_ge ? rem_sub[RW-1:0] : rem_shift[RW-1:0];
        n_quot    = {r_quot[VALUE_WIDTH-2:0], rem_ge};
    end

    // stack read for the next digit out, most significant first
    always_comb begin
        rd_count = r_count - 1'b1;
        rd_digit = r_stack[rd_count[IW-1:0]];
    end

    // status back to the controller
    always_comb begin
        o_stat.step_last = (r_bit == BW'(VALUE_WIDTH - 1));
        o_stat.quot_zero = (n_quot == '0);
        o_stat.neg       = r_neg;
        o_stat.idx_last  = (r_count == CW'(1));
        o_stat.out_free  = !r_o_valid || i_out_ready;
    end

    // divider and digit counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quot  <= in_mag;
            r_rem   <= '0;
            r_radix <= in_radix;
            r_neg   <= in_neg;
            r_bit   <= '0;
            r_count <= '0;
        end else if (i_cmd.step) begin
            r_quot <= n_quot;
            if (i_cmd.push) begin
                r_rem   <= '0;
                r_bit   <= '0;
                r_count <= r_count + 1'b1;
            end else begin
                r_rem <= n_rem;
                r_bit <= r_bit + 1'b1;
            end
        end else if (i_cmd.emit_digit) begin
            r_count <= rd_count;
        end
    end

    // digit stack, remainders in order of production
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stack[r_count[IW-1:0]] <= n_rem;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_character <= sbar_pkg::CHAR_MINUS;
            r_last      <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_character <= sbar_pkg::digit_char(rd_digit);
            r_last      <= (r_count == CW'(1));
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_character = r_character;
    assign o_last      = r_last;

endmodule

[hdl/sbar_ctrl.sv]
`timescale 1ns / 1ps
// controller: sequences load, division, sign and digit beats
module sbar_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  sbar_pkg::t_stat i_stat,
    output sbar_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DIV    = 2'd1;
    localparam logic [1:0] ST_SIGN   = 2'd2;
    localparam logic [1:0] ST_DIGITS = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state and commands
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_in_ready       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                if (i_stat.step_last) begin
                    o_cmd.push = 1'b1;
                    if (i_stat.quot_zero) begin
                        n_state = i_stat.neg ? ST_SIGN : ST_DIGITS;
                    end
                end
            end
            ST_SIGN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_stat.idx_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hdl/signed_binary_to_ascii_radix_core.sv]
`timescale 1ns / 1ps
// top level of the signed binary to ascii radix converter
// Converts one signed VALUE_WIDTH-bit number to its text in radix 2 to 36
// (radix codes below 2 act as 2, above 36 as 36), sent one character per
// output beat, most significant first, with a leading '-' for negative values
// and o_last on the final character. The most negative value converts exactly.
// Digits come from a bit-serial restoring divider that shifts through all
// VALUE_WIDTH quotient bits for each digit; the characters then go out at
// one character per cycle while the sink accepts. One number is in work at
// a time; the input is taken again once its last character has gone into
// the output register.
module signed_binary_to_ascii_radix_core #(
    parameter int VALUE_WIDTH = sbar_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [VALUE_WIDTH-1:0]     i_value,
    input  logic [sbar_pkg::RADIX_W-1:0]      i_radix,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [sbar_pkg::CHAR_W-1:0]       o_character,
    output logic                              o_last
);

`include "signed_binary_to_ascii_radix_core_macros.svh"

    sbar_pkg::t_cmd  w_cmd;
    sbar_pkg::t_stat w_stat;

    // controller
    sbar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath
    sbar_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_value     (i_value),
        .i_radix     (i_radix),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_character (o_character),
        .o_last      (o_last)
    );

    // checks on sequencing
    `SBAR_ASSERT_NOW(a_load_excl, i_clk, i_rst_n, w_cmd.load, !w_cmd.step && !w_cmd.emit_sign && !w_cmd.emit_digit, "load while busy")
    `SBAR_ASSERT_NEXT(a_sign_beat, i_clk, i_rst_n, w_cmd.emit_sign, o_valid && (o_character == sbar_pkg::CHAR_MINUS) && !o_last, "bad sign beat")
    `SBAR_ASSERT_NEXT(a_last_beat, i_clk, i_rst_n, w_cmd.emit_digit && w_stat.idx_last, o_valid && o_last && o_ready, "final digit not flagged")

endmodule

[test/tb_signed_binary_to_ascii_radix_core.sv]
`timescale 1ns / 1ps
// self-checking testbench for the signed binary to ascii radix converter
module tb_signed_binary_to_ascii_radix_core;

    localparam int VW           = sbar_pkg::VALUE_WIDTH_DEF;
    localparam int RW           = sbar_pkg::RADIX_W;
    localparam int CW           = sbar_pkg::CHAR_W;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int HOLD_CYCLES  = 2500;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_ITEMS = 300;
    localparam int REPORT_MAX   = 10;

    // one expected output beat
    typedef struct packed {
        logic [CW-1:0] code;
        logic          last;
    } t_char_beat;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic signed [VW-1:0]       i_value = '0;
    logic [RW-1:0]              i_radix = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [CW-1:0]              o_character;
    logic                       o_last;

    t_char_beat pending_chars[$];
    int         sent_numbers = 0;
    int         min_value_numbers = 0;
    int         clamped_numbers = 0;
    int         checked_chars = 0;
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         burst_left = 1;
    int         sink_cycle = 0;
    bit         hold_go = 1'b0;
    bit         hold_off = 1'b0;

    signed_binary_to_ascii_radix_core #(
        .VALUE_WIDTH(VW)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .i_radix     (i_radix),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

    // clock, 4 ns period
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // text of one number, queued as the characters the block should send
    function automatic void predict_text(input logic [VW-1:0] raw,
                                         input logic [RW-1:0] radix);
        logic [VW-1:0]      mag;
        logic [RW-1:0]      base;
        logic [RW-1:0]      digit;
        logic               neg;
        logic [CW-1:0]      rev[$];
        t_char_beat         beat;
        base = (radix < sbar_pkg::RADIX_MIN) ? sbar_pkg::RADIX_MIN :
               ((radix > sbar_pkg::RADIX_MAX) ? sbar_pkg::RADIX_MAX : radix);
        neg  = raw[VW-1];
        mag  = neg ? (~raw + 1'b1) : raw;
        // digits come out least significant first
        do begin
            digit = RW'(mag % base);
            if (digit < sbar_pkg::DEC_DIGITS) begin
                rev.push_back(sbar_pkg::CHAR_ZERO + CW'(digit));
            end else begin
                rev.push_back(sbar_pkg::CHAR_SEVEN + CW'(digit));
            end
            mag = mag / base;
        end while (mag != 0);
        if (neg) begin
            beat.code = sbar_pkg::CHAR_MINUS;
            beat.last = 1'b0;
            pending_chars.push_back(beat);
        end
        for (int i = rev.size() - 1; i >= 0; i--) begin
            beat.code = rev[i];
            beat.last = (i == 0);
            pending_chars.push_back(beat);
        end
    endfunction

    function automatic void note_mismatch(input string what, input t_char_beat want,
                                          input t_char_beat got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch (%s): expected char %h last %b, got char %h last %b",
                     what, want.code, want.last, got.code, got.last);
        end
    endfunction

    // offer one number and wait for the beat to be taken; bursts with gaps
    task automatic send_number(input logic [VW-1:0] value, input logic [RW-1:0] radix);
        i_valid <= 1'b1;
        i_value <= value;
        i_radix <= radix;
        do @(posedge i_clk); while (!o_ready);
        predict_text(value, radix);
        sent_numbers++;
        if (value == {1'b1, {(VW-1){1'b0}}}) begin
            min_value_numbers++;
        end
        if (radix < sbar_pkg::RADIX_MIN || radix > sbar_pkg::RADIX_MAX) begin
            clamped_numbers++;
        end
        burst_left--;
        if (burst_left <= 0) begin
            i_valid <= 1'b0;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(100, 700)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
    endtask

    // extremes of the value, digit ends and clamped radix codes
    task automatic test_directed_extremes();
        logic [VW-1:0] v_min;
        logic [VW-1:0] v_max;
        v_min = {1'b1, {(VW-1){1'b0}}};
        v_max = {1'b0, {(VW-1){1'b1}}};
        send_number('0, 6'd10);
        send_number('0, 6'd2);
        send_number(VW'(1), 6'd2);
        send_number('1, 6'd36);
        send_number(VW'(35), 6'd36);
        send_number(-VW'(35), 6'd36);
        send_number(VW'(9), 6'd10);
        send_number(v_max, 6'd2);
        send_number(v_max, 6'd36);
        send_number(v_max, 6'd10);
        send_number(v_min, 6'd2);
        send_number(v_min, 6'd3);
        send_number(v_min, 6'd10);
        send_number(v_min, 6'd16);
        send_number(v_min, 6'd36);
        send_number(VW'(12345678), 6'd8);
        send_number('1, 6'd16);
        // radix codes outside the range
        send_number(VW'(123456), 6'd0);
        send_number(-VW'(98765), 6'd1);
        send_number(VW'(1295), 6'd37);
        send_number(v_min, 6'd63);
        send_number(v_max, 6'd0);
    endtask

    // long sink hold-off while numbers keep arriving
    task automatic test_sink_hold_off();
        hold_go = 1'b1;
        for (int n = 0; n < 6; n++) begin
            send_number($urandom, 6'($urandom_range(2, 36)));
        end
    endtask

    // random numbers, weighted toward the awkward corners
    task automatic test_random_numbers();
        logic [VW-1:0]      value;
        logic [RW-1:0]      radix;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: value = $urandom;
                5, 6:          value = VW'($urandom_range(0, 200)) - VW'(100);
                7:             value = {1'b1, {(VW-1){1'b0}}} + VW'($urandom_range(0, 3));
                8:             value = {1'b0, {(VW-1){1'b1}}} - VW'($urandom_range(0, 3));
                default: begin
                    value = $urandom >> $urandom_range(0, VW - 1);
                    if ($urandom_range(0, 1) == 1) begin
                        value = ~value + 1'b1;
                    end
                end
            endcase
            if ($urandom_range(0, 4) == 0) begin
                radix = 6'($urandom_range(0, 63));
            end else begin
                radix = 6'($urandom_range(2, 36));
            end
            send_number(value, radix);
        end
    endtask

    // sink ready, cycling through stall patterns
    always @(posedge i_clk) begin
        sink_cycle <= sink_cycle + 1;
        if (hold_off) begin
            i_ready <= 1'b0;
        end else begin
            case (sink_cycle[10:9])
                2'd0: i_ready <= 1'b1;
                2'd1: i_ready <= 1'($urandom_range(0, 1));
                2'd2: i_ready <= (sink_cycle[2:0] == 3'd0);
                default: i_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // one long hold-off, counted here
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // compare each output beat with the oldest expected character
    always @(posedge i_clk) begin
        t_char_beat got;
        t_char_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            got.code = o_character;
            got.last = o_last;
            if (pending_chars.size() == 0) begin
                want = '0;
                note_mismatch("unexpected beat", want, got);
            end else begin
                want = pending_chars.pop_front();
                checked_chars++;
                if (got !== want) begin
                    note_mismatch("character", want, got);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("[signed_binary_to_ascii_radix_core] ERROR");
            $finish;
        end
    end

    // test sequence
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = $urandom_range(1, 8);
        test_directed_extremes();
        test_sink_hold_off();
        test_random_numbers();
        if (i_valid) begin
            i_valid <= 1'b0;
        end
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("converted %0d numbers (%0d most negative, %0d with clamped radix codes)",
                 sent_numbers, min_value_numbers, clamped_numbers);
        $display("checked %0d characters under bursts, sink stalls and a %0d-cycle hold-off",
                 checked_chars, HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("[signed_binary_to_ascii_radix_core] OK");
        end else begin
            $display("[signed_binary_to_ascii_radix_core] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/sbar_pkg.sv
hdl/sbar_datapath.sv
hdl/sbar_ctrl.sv
hdl/signed_binary_to_ascii_radix_core.sv
test/tb_signed_binary_to_ascii_radix_core.sv
